@@ hdl/lirs_pkg.sv @@
package lirs_pkg;

	localparam int SAMPLE_W      = 16;
	localparam int PHASE_W       = 20;
	localparam int CHAN_W        = 2;
	localparam int CFG_DATA_W    = 20;
	localparam int CFG_INDEX_W   = 1;
	localparam int FRAC_MAX      = 24;
	localparam int QUEUE_DEPTH   = 2;

	localparam int FRAC_BITS_DEF      = 16;
	localparam int MAX_CHANNELS_DEF   = 2;
	localparam int MAX_OUT_PER_IN_DEF = 8;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP    = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 1'b1;

	localparam logic [PHASE_W-1:0] PHASE_STEP_RST    = 20'd65536;
	localparam logic [CHAN_W-1:0]  CHANNEL_COUNT_RST = 2'd2;
	localparam logic [CHAN_W-1:0]  CH_MONO           = 2'd1;

	// classified input frame
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
		logic                       last;
		logic                       pass;
	} item_t;

	// one result to compute
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] s0_left;
		logic signed [SAMPLE_W-1:0] s1_left;
		logic signed [SAMPLE_W-1:0] s0_right;
		logic signed [SAMPLE_W-1:0] s1_right;
		logic [FRAC_MAX-1:0]        frac;
		logic                       has_data;
		logic                       last;
		logic                       pass;
	} job_t;

endpackage

@@ hdl/lirs_front.sv @@
module lirs_front #(
	parameter int FRAC_BITS    = lirs_pkg::FRAC_BITS_DEF,
	parameter int MAX_CHANNELS = lirs_pkg::MAX_CHANNELS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [lirs_pkg::SAMPLE_W-1:0] left_sample,
	input  logic signed [lirs_pkg::SAMPLE_W-1:0] right_sample,
	input  logic                                 last_frame,
	input  logic [lirs_pkg::PHASE_W-1:0]         phase_step,
	input  logic [lirs_pkg::CHAN_W-1:0]          channel_count,
	output logic                                 head_valid,
	output lirs_pkg::item_t                      head,
	input  logic                                 pop
);
	import lirs_pkg::*;

	localparam int CMP_W = (PHASE_W > FRAC_BITS) ? PHASE_W : FRAC_BITS + 1;
	localparam logic [CMP_W-1:0] ONE_C = CMP_W'(1) << FRAC_BITS;
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;
	logic              do_pop;
	logic              stereo;
	item_t             item;

	// classify at the door: equal-rate pass-through and channel mask
	always_comb begin
		stereo     = (MAX_CHANNELS > 1) && (channel_count != CH_MONO);
		item.left  = left_sample;
		item.right = stereo ? right_sample : '0;
		item.last  = last_frame;
		item.pass  = (CMP_W'(phase_step) == ONE_C);
	end

	assign in_stall   = (count_q == CNT_W'(QUEUE_DEPTH));
	assign push       = in_valid && !in_stall;
	assign head_valid = (count_q != '0);
	assign do_pop     = pop && head_valid;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, do_pop})
				2'b10: count_q <= count_q + CNT_W'(1);
				2'b01: count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hdl/lirs_interp.sv @@
module lirs_interp #(
	parameter int FRAC_BITS = lirs_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 job_valid,
	input  lirs_pkg::job_t                       job,
	output logic                                 job_ready,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [lirs_pkg::SAMPLE_W-1:0] out_left,
	output logic signed [lirs_pkg::SAMPLE_W-1:0] out_right,
	output logic                                 has_data,
	output logic                                 last_out
);
	import lirs_pkg::*;

	localparam int AW = FRAC_BITS + 19;
	localparam int TW = AW + 16;
	localparam int SH = 15 + FRAC_BITS;
	localparam logic signed [TW-1:0] BIAS = {{(TW - SH){1'b0}}, {SH{1'b1}}};
	localparam logic signed [TW-1:0] QMAX = TW'(32767);
	localparam logic signed [TW-1:0] QMIN = TW'(-32768);

	logic                       valid_s1;
	logic signed [AW-1:0]       acc_l_s1;
	logic signed [AW-1:0]       acc_r_s1;
	logic                       pass_s1;
	logic                       has_s1;
	logic                       last_s1;
	logic                       out_valid_q;
	logic                       out_adv;
	logic signed [AW-1:0]       acc_l;
	logic signed [AW-1:0]       acc_r;

	// s0*2^F + frac*(s1-s0)
	function automatic logic signed [AW-1:0] lerp(
		input logic signed [SAMPLE_W-1:0] s0,
		input logic signed [SAMPLE_W-1:0] s1,
		input logic [FRAC_MAX-1:0]        frac
	);
		logic signed [SAMPLE_W:0]          diff;
		logic signed [FRAC_BITS:0]         fs;
		logic signed [FRAC_BITS+SAMPLE_W+1:0] prod;
		diff = SAMPLE_W'(s1) - SAMPLE_W'(s0);
		diff = (SAMPLE_W + 1)'(s1) - (SAMPLE_W + 1)'(s0);
		fs   = {1'b0, frac[FRAC_BITS-1:0]};
		prod = diff * fs;
		return (AW'(s0) <<< FRAC_BITS) + AW'(prod);
	endfunction

	// times 32767/32768, drop the fraction toward zero, clamp
	function automatic logic signed [SAMPLE_W-1:0] scale16(input logic signed [AW-1:0] a);
		logic signed [TW-1:0] t;
		logic signed [TW-1:0] q;
		t = (TW'(a) <<< 15) - TW'(a);
		if (t < 0) begin
			t = t + BIAS;
		end
		q = t >>> SH;
		if (q > QMAX) begin
			q = QMAX;
		end else if (q < QMIN) begin
			q = QMIN;
		end
		return q[SAMPLE_W-1:0];
	endfunction

	assign acc_l     = lerp(job.s0_left, job.s1_left, job.frac);
	assign acc_r     = lerp(job.s0_right, job.s1_right, job.frac);
	assign out_adv   = !out_valid_q || !out_stall;
	assign job_ready = !valid_s1 || out_adv;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk) begin
		if (job_valid && job_ready) begin
			acc_l_s1 <= acc_l;
			acc_r_s1 <= acc_r;
			pass_s1  <= job.pass;
			has_s1   <= job.has_data;
			last_s1  <= job.last;
		end
		if (valid_s1 && out_adv) begin
			out_left  <= pass_s1 ? acc_l_s1[FRAC_BITS+SAMPLE_W-1:FRAC_BITS] : scale16(acc_l_s1);
			out_right <= pass_s1 ? acc_r_s1[FRAC_BITS+SAMPLE_W-1:FRAC_BITS] : scale16(acc_r_s1);
			has_data  <= has_s1;
			last_out  <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (job_ready) begin
				valid_s1 <= job_valid;
			end
			if (out_adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

endmodule

@@ hdl/lirs_seq.sv @@
module lirs_seq #(
	parameter int FRAC_BITS      = lirs_pkg::FRAC_BITS_DEF,
	parameter int MAX_OUT_PER_IN = lirs_pkg::MAX_OUT_PER_IN_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [lirs_pkg::PHASE_W-1:0] phase_step,
	input  logic                         head_valid,
	input  lirs_pkg::item_t              head,
	output logic                         pop,
	output logic                         job_valid,
	output lirs_pkg::job_t               job,
	input  logic                         job_ready
);
	import lirs_pkg::*;

	localparam int RW = 32 + FRAC_BITS;
	localparam int CW = $clog2(MAX_OUT_PER_IN + 1);
	localparam logic [RW-1:0] ONE_R   = RW'(1) << FRAC_BITS;
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_OUT_PER_IN);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_A    = 2'd1;
	localparam logic [1:0] ST_B    = 2'd2;
	localparam logic [1:0] ST_MARK = 2'd3;

	logic [1:0]                 state_q;
	logic [RW-1:0]              rel_q;
	logic [CW-1:0]              cnt_q;
	logic                       emitted_q;
	logic                       have_prev_q;
	logic signed [SAMPLE_W-1:0] prev_l_q;
	logic signed [SAMPLE_W-1:0] prev_r_q;

	logic [RW-1:0] rel_inc;
	logic [CW-1:0] cnt_inc;
	logic          lt_one;
	logic          inc_lt_one;
	logic          inc_lt_two;
	logic          emit;
	logic          fire;

	// position of the next output, relative to the held frame
	assign rel_inc    = rel_q + RW'(phase_step);
	assign cnt_inc    = cnt_q + CW'(1);
	assign lt_one     = (rel_q[RW-1:FRAC_BITS] == '0);
	assign inc_lt_one = (rel_inc[RW-1:FRAC_BITS] == '0);
	assign inc_lt_two = (rel_inc[RW-1:FRAC_BITS] == (RW - FRAC_BITS)'(1));
	assign emit       = lt_one && (cnt_q < CNT_MAX);
	assign fire       = job_valid && job_ready;

	always_comb begin
		job_valid = 1'b0;
		pop       = 1'b0;
		job       = '0;
		job.frac  = FRAC_MAX'(rel_q[FRAC_BITS-1:0]);
		unique case (state_q)
			ST_IDLE: begin
				if (head_valid && head.pass) begin
					job_valid    = 1'b1;
					job.s0_left  = head.left;
					job.s0_right = head.right;
					job.s1_left  = head.left;
					job.s1_right = head.right;
					job.frac     = '0;
					job.has_data = 1'b1;
					job.last     = head.last;
					job.pass     = 1'b1;
					pop          = job_ready;
				end else if (head_valid && !have_prev_q) begin
					pop = !head.last;
				end
			end
			ST_A: begin
				job_valid    = emit;
				job.s0_left  = prev_l_q;
				job.s0_right = prev_r_q;
				job.s1_left  = head.left;
				job.s1_right = head.right;
				job.has_data = 1'b1;
				// final only if the tail interval stays empty
				job.last     = head.last && !inc_lt_one && !inc_lt_two;
				pop          = !emit && !head.last;
			end
			ST_B: begin
				job_valid    = emit;
				job.s0_left  = head.left;
				job.s0_right = head.right;
				job.s1_left  = head.left;
				job.s1_right = head.right;
				job.has_data = 1'b1;
				job.last     = !inc_lt_one || (cnt_inc == CNT_MAX);
				pop          = !emit && emitted_q;
			end
			ST_MARK: begin
				job_valid = 1'b1;
				job.frac  = '0;
				job.last  = 1'b1;
				pop       = job_ready;
			end
			default: begin
				job_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rel_q       <= '0;
			cnt_q       <= '0;
			emitted_q   <= 1'b0;
			have_prev_q <= 1'b0;
			prev_l_q    <= '0;
			prev_r_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (head_valid) begin
						cnt_q     <= '0;
						emitted_q <= 1'b0;
						if (head.pass) begin
							if (job_ready) begin
								prev_l_q    <= head.left;
								prev_r_q    <= head.right;
								have_prev_q <= !head.last;
								rel_q       <= head.last ? '0 : ONE_R;
							end
						end else if (!have_prev_q) begin
							prev_l_q    <= head.left;
							prev_r_q    <= head.right;
							have_prev_q <= 1'b1;
							if (head.last) begin
								state_q <= ST_B;
							end
						end else begin
							state_q <= ST_A;
						end
					end
				end
				ST_A: begin
					if (emit) begin
						if (fire) begin
							rel_q     <= rel_inc;
							cnt_q     <= cnt_inc;
							emitted_q <= 1'b1;
						end
					end else begin
						// skip the rest of the interval, advance to the new frame
						rel_q    <= lt_one ? '0 : rel_q - ONE_R;
						prev_l_q <= head.left;
						prev_r_q <= head.right;
						cnt_q    <= '0;
						state_q  <= head.last ? ST_B : ST_IDLE;
					end
				end
				ST_B: begin
					if (emit) begin
						if (fire) begin
							rel_q     <= rel_inc;
							cnt_q     <= cnt_inc;
							emitted_q <= 1'b1;
						end
					end else if (emitted_q) begin
						rel_q       <= '0;
						have_prev_q <= 1'b0;
						state_q     <= ST_IDLE;
					end else begin
						state_q <= ST_MARK;
					end
				end
				ST_MARK: begin
					if (job_ready) begin
						rel_q       <= '0;
						have_prev_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_marker_only_in_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(job_valid && !job.has_data) |-> (state_q == ST_MARK))
		else $error("bare end marker issued outside marker state");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head_valid && head.last) |=> (!have_prev_q && rel_q == '0))
		else $error("stream state not cleared after final frame");

	a_busy_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_A || state_q == ST_B || state_q == ST_MARK) |-> head_valid)
		else $error("interval work without a queued frame");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> (cnt_q < CNT_MAX || state_q == ST_IDLE || state_q == ST_MARK))
		else $error("too many outputs in one interval");

endmodule

@@ hdl/linear_interp_resampler_core.sv @@
// On its way to its first result a frame passes the queue write, the sequencer
//   issue, the interpolation product and the output register.
// The sequencer issues one result a cycle while the datapath takes jobs; besides its
//   results a frame takes issue time per interval close and to start, except at equal rates.
// Reset (arst_n low, asynchronous): queue emptied, stream state cleared,
//   phase_step 65536, channel_count 2; no clearing pass is needed.
module linear_interp_resampler_core #(
	parameter int FRAC_BITS      = lirs_pkg::FRAC_BITS_DEF,
	parameter int MAX_CHANNELS   = lirs_pkg::MAX_CHANNELS_DEF,
	parameter int MAX_OUT_PER_IN = lirs_pkg::MAX_OUT_PER_IN_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// configuration write port
	input  logic                                   cfg_we,
	input  logic [lirs_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [lirs_pkg::CFG_DATA_W-1:0]        cfg_data,
	// input frames
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [lirs_pkg::SAMPLE_W-1:0]   left_sample,
	input  logic signed [lirs_pkg::SAMPLE_W-1:0]   right_sample,
	input  logic                                   last_frame,
	// resampled frames
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [lirs_pkg::SAMPLE_W-1:0]   out_left,
	output logic signed [lirs_pkg::SAMPLE_W-1:0]   out_right,
	output logic                                   has_data,
	output logic                                   last_out
);
	import lirs_pkg::*;

	logic [PHASE_W-1:0] phase_step_q;
	logic [CHAN_W-1:0]  channel_count_q;

	logic  head_valid;
	item_t head;
	logic  pop;
	logic  job_valid;
	job_t  job;
	logic  job_ready;

	// Configuration registers. Write them only while the block is idle; the
	// block does not enforce this, and front and back both read them live.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q    <= PHASE_STEP_RST;
			channel_count_q <= CHANNEL_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PHASE_STEP:    phase_step_q    <= cfg_data[PHASE_W-1:0];
				REG_CHANNEL_COUNT: channel_count_q <= cfg_data[CHAN_W-1:0];
				default:           phase_step_q    <= phase_step_q;
			endcase
		end
	end

	// Front: take one beat, mask the right channel in mono, flag the
	// equal-rate pass-through case, and park the frame in a short queue.
	lirs_front #(
		.FRAC_BITS    (FRAC_BITS),
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.left_sample   (left_sample),
		.right_sample  (right_sample),
		.last_frame    (last_frame),
		.phase_step    (phase_step_q),
		.channel_count (channel_count_q),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop)
	);

	// Back, control half: walk the output position across the interval that
	// the queued frame closes, then across the tail interval on the last frame.
	// The position is held relative to the current frame, so no frame counter
	// is needed. The last flag is decided ahead, at issue time.
	lirs_seq #(
		.FRAC_BITS      (FRAC_BITS),
		.MAX_OUT_PER_IN (MAX_OUT_PER_IN)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.phase_step (phase_step_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.job_valid  (job_valid),
		.job        (job),
		.job_ready  (job_ready)
	);

	// Back, datapath half: one product per channel, registered, then, except on
	// pass-through, scale, truncate toward zero and clamp into the output register.
	// The output register holds a stalled beat while the product stage may still fill.
	lirs_interp #(
		.FRAC_BITS (FRAC_BITS)
	) u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.job_ready (job_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_left  (out_left),
		.out_right (out_right),
		.has_data  (has_data),
		.last_out  (last_out)
	);

endmodule
